// ===== sv/deq_pkg.sv =====
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

    typedef struct packed {
        logic take;
        logic load;
    } t_cmd;

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - ADDR_W'(1);
    endfunction

endpackage

// ===== sv/deq_if.sv =====
interface deq_req_if;
    logic                                valid;
    logic                                ready;
    logic        [deq_pkg::KIND_W-1:0]   kind;
    logic signed [deq_pkg::WORD_W-1:0]   value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [deq_pkg::WORD_W-1:0]   popped;
    logic        [deq_pkg::STAT_W-1:0]   status;
    logic        [deq_pkg::CNT_W-1:0]    count;
    logic                                vacant;

    modport source (output valid, output popped, output status, output count,
                    output vacant, input ready);
    modport sink   (input valid, input popped, input status, input count,
                    input vacant, output ready);
endinterface

// ===== sv/deq_ram.sv =====
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/deq_ctrl.sv =====
module deq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output deq_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_SEND);
    assign o_cmd.take  = (r_state == S_IDLE) && i_req_valid;
    assign o_cmd.load  = (r_state == S_READ);

endmodule

// ===== sv/deq_dp.sv =====
module deq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  deq_pkg::t_cmd                       i_cmd,
    input  logic        [deq_pkg::KIND_W-1:0]   i_kind,
    input  logic signed [deq_pkg::WORD_W-1:0]   i_value,
    output logic signed [deq_pkg::WORD_W-1:0]   o_popped,
    output logic        [deq_pkg::STAT_W-1:0]   o_status,
    output logic        [deq_pkg::CNT_W-1:0]    o_count,
    output logic                                o_vacant
);

    logic [deq_pkg::ADDR_W-1:0] r_front;
    logic [deq_pkg::ADDR_W-1:0] r_back;
    logic [deq_pkg::CNT_W-1:0]  r_count;
    logic [deq_pkg::STAT_W-1:0] r_status;
    logic                       r_do_pop;
    logic [deq_pkg::WORD_W-1:0] r_popped;

    logic                       push_front;
    logic                       push_back;
    logic                       pop_front;
    logic                       pop_back;
    logic                       is_full;
    logic                       no_entries;
    logic                       push_ok;
    logic                       pop_ok;
    logic                       we;
    logic [deq_pkg::ADDR_W-1:0] waddr;
    logic [deq_pkg::ADDR_W-1:0] raddr;
    logic [deq_pkg::WORD_W-1:0] rdata;
    logic [deq_pkg::STAT_W-1:0] status;

    assign push_front = (i_kind == deq_pkg::KIND_PUSH_FRONT);
    assign push_back  = (i_kind == deq_pkg::KIND_PUSH_BACK);
    assign pop_front  = (i_kind == deq_pkg::KIND_POP_FRONT);
    assign pop_back   = (i_kind == deq_pkg::KIND_POP_BACK);
    assign is_full    = (r_count == deq_pkg::FULL_CNT);
    assign no_entries = (r_count == '0);
    assign push_ok    = (push_front || push_back) && !is_full;
    assign pop_ok     = (pop_front || pop_back) && !no_entries;

    always_comb begin
        priority if ((push_front || push_back) && is_full) begin
            status = deq_pkg::ST_FULL;
        end else if ((pop_front || pop_back) && no_entries) begin
            status = deq_pkg::ST_EMPTY;
        end else begin
            status = deq_pkg::ST_OK;
        end
    end

    assign we    = i_cmd.take && push_ok;
    assign waddr = push_front ? deq_pkg::wrap_dec(r_front) : r_back;
    assign raddr = pop_front ? r_front : deq_pkg::wrap_dec(r_back);

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.take) begin
            if (i_kind == deq_pkg::KIND_CLEAR) begin
                r_front <= '0;
                r_back  <= '0;
                r_count <= '0;
            end else if (push_ok) begin
                if (push_front) begin
                    r_front <= deq_pkg::wrap_dec(r_front);
                end else begin
                    r_back <= deq_pkg::wrap_inc(r_back);
                end
                r_count <= r_count + deq_pkg::CNT_W'(1);
            end else if (pop_ok) begin
                if (pop_front) begin
                    r_front <= deq_pkg::wrap_inc(r_front);
                end else begin
                    r_back <= deq_pkg::wrap_dec(r_back);
                end
                r_count <= r_count - deq_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_status <= status;
            r_do_pop <= pop_ok;
        end
        if (i_cmd.load) begin
            r_popped <= r_do_pop ? rdata : '0;
        end
    end

    assign o_popped = r_popped;
    assign o_status = r_status;
    assign o_count  = r_count;
    assign o_vacant = no_entries;

endmodule

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words in a circular store of
// deq_pkg::DEPTH entries. Each request pushes at the front or back, pops from
// the front or back, or clears; it returns exactly one response carrying the
// popped word (zero unless a pop succeeded), a status (ok, pop on empty, push
// on full), the entry count after the request and an empty flag. A failed
// request leaves the queue untouched; unused kind codes act as no-ops. One
// request is in flight at a time: the acceptance cycle updates the indices
// and issues the store access, the next cycle collects the registered read of
// the store, and the response then holds until taken. The next request is
// accepted in the cycle after the response is taken.
module double_ended_queue (
    input  logic  i_clk,
    input  logic  i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);

    deq_pkg::t_cmd cmd;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    deq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_kind   (i_req.kind),
        .i_value  (i_req.value),
        .o_popped (o_rsp.popped),
        .o_status (o_rsp.status),
        .o_count  (o_rsp.count),
        .o_vacant (o_rsp.vacant)
    );

endmodule

// ===== sv/deq_checker.sv =====
module deq_assertions (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_ready,
    input  logic signed [deq_pkg::WORD_W-1:0]   i_popped,
    input  logic        [deq_pkg::STAT_W-1:0]   i_status,
    input  logic        [deq_pkg::CNT_W-1:0]    i_count,
    input  logic                                i_vacant
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_popped) && $stable(i_status))
        else $error("response dropped or changed while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_vacant == (i_count == '0)))
        else $error("empty flag disagrees with count");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_count <= deq_pkg::FULL_CNT)
        else $error("count beyond capacity");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == deq_pkg::ST_EMPTY |-> i_count == '0 && i_popped == '0)
        else $error("failed pop with entries held or nonzero word");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == deq_pkg::ST_FULL |-> i_count == deq_pkg::FULL_CNT)
        else $error("failed push while not full");

endmodule

bind double_ended_queue deq_assertions u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_popped (o_rsp.popped),
    .i_status (o_rsp.status),
    .i_count  (o_rsp.count),
    .i_vacant (o_rsp.vacant)
);
